// File: rtl/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg
// Types and codes shared by the heightfield sampler and its channel interfaces.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_BITS   = 16;
  localparam int EDGE_BITS   = 9;
  localparam int COORD_BITS  = 17;
  localparam int POS_BITS    = 24;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_NEAREST = 2'd1;
  localparam logic [1:0] MODE_SMOOTH  = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_MAX       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_Z_MIN       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_Z_MAX       = 3'd5;

  typedef struct packed {
    logic [1:0]                   mode;
    logic [ADDR_BITS-1:0]         load_index;
    logic signed [POS_BITS-1:0]   load_height;
    logic [COORD_BITS-1:0]        coord_u;
    logic [COORD_BITS-1:0]        coord_v;
  } req_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic signed [POS_BITS-1:0] pos_z;
  } res_t;

endpackage

// File: rtl/hbs_if.sv
// ----------------------------------------------------------------------------
// hbs_if
// Valid/ready channels for sampler requests and results.
// ----------------------------------------------------------------------------
interface hbs_req_if;
  logic          valid;
  logic          ready;
  hbs_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hbs_res_if;
  logic          valid;
  logic          ready;
  hbs_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/heightfield_bilinear_sampler_unit.sv
// ----------------------------------------------------------------------------
// heightfield_bilinear_sampler_unit
// Height grid store with nearest and bilinear sampling and box mapping.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while not stalled and returns one result
// per sample request, in request order; loads return nothing. The height grid
// lives in four copies of a 65536-entry synchronous memory, every load writes
// all four and each sample reads one corner from each, so the four corner
// reads never compete for a port. Loads and reads happen in the same stage,
// in request order, so a sample always sees every earlier load. The pipeline
// stalls only when the result register is full and not taken. Sampling an
// entry never loaded returns an undefined height.
module heightfield_bilinear_sampler_unit #(
  parameter int MAX_GRID_EDGE = 256,
  parameter int HEIGHT_BITS   = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [hbs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [hbs_pkg::POS_BITS-1:0]       cfg_data,
  hbs_req_if.sink                            req,
  hbs_res_if.source                          res
);

  localparam int SB = (HEIGHT_BITS < 24) ? HEIGHT_BITS : 24;
  localparam int EB = hbs_pkg::EDGE_BITS;
  localparam int AB = hbs_pkg::ADDR_BITS;
  localparam int CB = hbs_pkg::COORD_BITS;
  localparam int PB = hbs_pkg::POS_BITS;
  localparam int PUB = CB + EB;

  logic [EB-1:0] grid_width, grid_height;
  logic signed [PB-1:0] x_min, x_max, z_min, z_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= EB'(256);
      grid_height <= EB'(256);
      x_min <= '0;
      x_max <= '0;
      z_min <= '0;
      z_max <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbs_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data[EB-1:0];
        hbs_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data[EB-1:0];
        hbs_pkg::REG_X_MIN:       x_min <= cfg_data;
        hbs_pkg::REG_X_MAX:       x_max <= cfg_data;
        hbs_pkg::REG_Z_MIN:       z_min <= cfg_data;
        hbs_pkg::REG_Z_MAX:       z_max <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [EB-1:0] w_eff, h_eff;

  always_comb begin
    if (grid_width < EB'(2)) w_eff = EB'(2);
    else if (int'(grid_width) > MAX_GRID_EDGE) w_eff = EB'(MAX_GRID_EDGE);
    else w_eff = grid_width;
    if (grid_height < EB'(2)) h_eff = EB'(2);
    else if (int'(grid_height) > MAX_GRID_EDGE) h_eff = EB'(MAX_GRID_EDGE);
    else h_eff = grid_height;
  end

  logic en;
  assign en = !res.valid || res.ready;
  assign req.ready = en;

  // stage 1: captured request
  logic s1_valid;
  logic [1:0] s1_mode;
  logic [AB-1:0] s1_idx;
  logic signed [SB-1:0] s1_h;
  logic [CB-1:0] s1_u, s1_v;

  // stage 2: scaled coordinates and box products
  logic s2_valid;
  logic [1:0] s2_mode;
  logic [AB-1:0] s2_idx;
  logic signed [SB-1:0] s2_h;
  logic [PUB-1:0] s2_pu, s2_pv;
  logic signed [42:0] s2_bx, s2_bz;

  // stage 3: memory data
  logic s3_valid;
  logic [1:0] s3_mode;
  logic [15:0] s3_fx, s3_fz;
  logic signed [PB-1:0] s3_px, s3_pz;
  logic signed [SB-1:0] q00, q10, q01, q11;

  // stage 4: row blends
  logic s4_valid;
  logic [1:0] s4_mode;
  logic [15:0] s4_fz;
  logic signed [PB-1:0] s4_px, s4_pz, s4_near;
  logic signed [47:0] s4_r0, s4_r1;

  // stage 1 -> 2
  logic [CB-1:0] u_sat, v_sat;
  logic signed [PB:0] dx, dz;
  logic [PUB-1:0] pu, pv;
  logic signed [42:0] bx, bz;

  always_comb begin
    u_sat = (req.data.coord_u > CB'(65536)) ? CB'(65536) : req.data.coord_u;
    v_sat = (req.data.coord_v > CB'(65536)) ? CB'(65536) : req.data.coord_v;
    dx = (PB+1)'(x_max) - (PB+1)'(x_min);
    dz = (PB+1)'(z_max) - (PB+1)'(z_min);
    pu = PUB'(s1_u) * PUB'(w_eff);
    pv = PUB'(s1_v) * PUB'(h_eff);
    bx = $signed({1'b0, s1_u}) * dx;
    bz = $signed({1'b0, s1_v}) * dz;
  end

  // stage 2 -> 3
  logic [EB:0] cx, cz, cx_raw, cz_raw;
  logic [18:0] row_base;
  logic [AB-1:0] a00, a10, a01, a11;
  logic signed [26:0] bx_sh, bz_sh;
  logic signed [PB-1:0] px, pz;

  always_comb begin
    cx_raw = s2_pu[PUB-1:16];
    cz_raw = s2_pv[PUB-1:16];
    cx = (cx_raw >= ({1'b0, w_eff} - 10'd1)) ? ({1'b0, w_eff} - 10'd2) : cx_raw;
    cz = (cz_raw >= ({1'b0, h_eff} - 10'd1)) ? ({1'b0, h_eff} - 10'd2) : cz_raw;
    row_base = 19'(cz) * 19'(w_eff) + 19'(cx);
    a00 = row_base[AB-1:0];
    a10 = a00 + AB'(1);
    a01 = a00 + AB'(w_eff);
    a11 = a01 + AB'(1);
    bx_sh = 27'(s2_bx >>> 16);
    bz_sh = 27'(s2_bz >>> 16);
    px = PB'(bx_sh + 27'(x_min));
    pz = PB'(bz_sh + 27'(z_min));
  end

  logic wr;
  assign wr = en && s2_valid && (s2_mode == hbs_pkg::MODE_LOAD);

  logic signed [SB-1:0] mem00 [hbs_pkg::STORE_DEPTH];
  logic signed [SB-1:0] mem10 [hbs_pkg::STORE_DEPTH];
  logic signed [SB-1:0] mem01 [hbs_pkg::STORE_DEPTH];
  logic signed [SB-1:0] mem11 [hbs_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr) mem00[s2_idx] <= s2_h;
    if (en) q00 <= mem00[a00];
  end

  always_ff @(posedge clk) begin
    if (wr) mem10[s2_idx] <= s2_h;
    if (en) q10 <= mem10[a10];
  end

  always_ff @(posedge clk) begin
    if (wr) mem01[s2_idx] <= s2_h;
    if (en) q01 <= mem01[a01];
  end

  always_ff @(posedge clk) begin
    if (wr) mem11[s2_idx] <= s2_h;
    if (en) q11 <= mem11[a11];
  end

  // stage 3 -> 4
  logic signed [17:0] wx0, wx1;
  logic signed [47:0] p00, p10, p01, p11;

  always_comb begin
    wx1 = $signed({2'b00, s3_fx});
    wx0 = 18'sd65536 - wx1;
    p00 = q00 * wx0;
    p10 = q10 * wx1;
    p01 = q01 * wx0;
    p11 = q11 * wx1;
  end

  // stage 4 -> result
  logic signed [17:0] wz0, wz1;
  logic signed [65:0] m0, m1, acc;
  logic signed [PB-1:0] y;

  always_comb begin
    wz1 = $signed({2'b00, s4_fz});
    wz0 = 18'sd65536 - wz1;
    m0 = s4_r0 * wz0;
    m1 = s4_r1 * wz1;
    acc = m0 + m1;
    y = (s4_mode == hbs_pkg::MODE_NEAREST) ? s4_near : acc[55:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= req.valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid && (s2_mode == hbs_pkg::MODE_NEAREST ||
                                s2_mode == hbs_pkg::MODE_SMOOTH);
      s4_valid  <= s3_valid;
      res.valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode <= req.data.mode;
      s1_idx  <= req.data.load_index;
      s1_h    <= req.data.load_height[SB-1:0];
      s1_u    <= u_sat;
      s1_v    <= v_sat;

      s2_mode <= s1_mode;
      s2_idx  <= s1_idx;
      s2_h    <= s1_h;
      s2_pu   <= pu;
      s2_pv   <= pv;
      s2_bx   <= bx;
      s2_bz   <= bz;

      s3_mode <= s2_mode;
      s3_fx   <= s2_pu[15:0];
      s3_fz   <= s2_pv[15:0];
      s3_px   <= px;
      s3_pz   <= pz;

      s4_mode <= s3_mode;
      s4_fz   <= s3_fz;
      s4_px   <= s3_px;
      s4_pz   <= s3_pz;
      s4_near <= PB'(q00);
      s4_r0   <= p00 + p10;
      s4_r1   <= p01 + p11;

      res.data.pos_x <= s4_px;
      res.data.pos_y <= y;
      res.data.pos_z <= s4_pz;
    end
  end

endmodule

// File: bench/hbs_checker.sv
// ----------------------------------------------------------------------------
// hbs_checker
// Watches the configuration port and both channels of the heightfield
// sampler, keeps its own height grid and box registers, works out the
// position for every accepted sample request and compares each accepted
// result field by field, in order.
// ----------------------------------------------------------------------------
module hbs_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hbs_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [hbs_pkg::POS_BITS-1:0]     cfg_data,
  hbs_req_if                               req,
  hbs_res_if                               res,
  output int                               errors,
  output int                               pending
);

  localparam int GRID_EDGE_MAX = 256;
  localparam int PB = hbs_pkg::POS_BITS;
  localparam int EB = hbs_pkg::EDGE_BITS;
  localparam int AB = hbs_pkg::ADDR_BITS;
  localparam int CB = hbs_pkg::COORD_BITS;

  logic signed [PB-1:0] heights [0:hbs_pkg::STORE_DEPTH-1];
  logic [EB-1:0] grid_w;
  logic [EB-1:0] grid_h;
  longint x_lo, x_hi, z_lo, z_hi;
  hbs_pkg::res_t positions_due[$];
  hbs_pkg::res_t got, want;

  function automatic longint unsigned clamp_edge(logic [EB-1:0] e);
    if (e < EB'(2)) return 2;
    if (int'(e) > GRID_EDGE_MAX) return GRID_EDGE_MAX;
    return 64'(e);
  endfunction

  function automatic longint height_at(longint unsigned col, longint unsigned row,
                                       longint unsigned w);
    logic [AB-1:0] addr;
    addr = AB'(row * w + col);
    return longint'(heights[addr]);
  endfunction

  function automatic hbs_pkg::res_t sample_position(hbs_pkg::req_t r);
    longint unsigned u, v, w, ht, pu, pv, cx, cz;
    longint fx, fz, y, s, bx, bz;
    hbs_pkg::res_t p;
    u  = (r.coord_u > CB'(65536)) ? 64'd65536 : 64'(r.coord_u);
    v  = (r.coord_v > CB'(65536)) ? 64'd65536 : 64'(r.coord_v);
    w  = clamp_edge(grid_w);
    ht = clamp_edge(grid_h);
    pu = u * w;
    pv = v * ht;
    cx = pu >> 16;
    cz = pv >> 16;
    fx = longint'(pu & 64'hFFFF);
    fz = longint'(pv & 64'hFFFF);
    if (cx >= w - 1) cx = w - 2;
    if (cz >= ht - 1) cz = ht - 2;
    if (r.mode == hbs_pkg::MODE_NEAREST) begin
      y = height_at(cx, cz, w);
    end else begin
      s = height_at(cx, cz, w) * (65536 - fx) * (65536 - fz)
        + height_at(cx + 1, cz, w) * fx * (65536 - fz)
        + height_at(cx, cz + 1, w) * (65536 - fx) * fz
        + height_at(cx + 1, cz + 1, w) * fx * fz;
      y = s >>> 32;
    end
    bx = x_lo + ((longint'(u) * (x_hi - x_lo)) >>> 16);
    bz = z_lo + ((longint'(v) * (z_hi - z_lo)) >>> 16);
    p.pos_x = bx[PB-1:0];
    p.pos_y = y[PB-1:0];
    p.pos_z = bz[PB-1:0];
    return p;
  endfunction

  task automatic report(string field, logic [PB-1:0] e, logic [PB-1:0] a);
    errors++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, e, a);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      grid_w = EB'(256);
      grid_h = EB'(256);
      x_lo = 0; x_hi = 0; z_lo = 0; z_hi = 0;
      errors = 0;
      positions_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hbs_pkg::REG_GRID_WIDTH:  grid_w = cfg_data[EB-1:0];
          hbs_pkg::REG_GRID_HEIGHT: grid_h = cfg_data[EB-1:0];
          hbs_pkg::REG_X_MIN:       x_lo = longint'($signed(cfg_data));
          hbs_pkg::REG_X_MAX:       x_hi = longint'($signed(cfg_data));
          hbs_pkg::REG_Z_MIN:       z_lo = longint'($signed(cfg_data));
          hbs_pkg::REG_Z_MAX:       z_hi = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        case (req.data.mode) inside
          hbs_pkg::MODE_LOAD:
            heights[req.data.load_index] = req.data.load_height;
          hbs_pkg::MODE_NEAREST, hbs_pkg::MODE_SMOOTH:
            positions_due.push_back(sample_position(req.data));
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        got = res.data;
        if (positions_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual %h %h %h", $time,
                   got.pos_x, got.pos_y, got.pos_z);
        end else begin
          want = positions_due.pop_front();
          if (got.pos_x !== want.pos_x) report("pos_x", want.pos_x, got.pos_x);
          if (got.pos_y !== want.pos_y) report("pos_y", want.pos_y, got.pos_y);
          if (got.pos_z !== want.pos_z) report("pos_z", want.pos_z, got.pos_z);
        end
      end
    end
    pending = positions_due.size();
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the heightfield sampler through several grid and box settings with
// directed and random load and sample requests, random gaps and result
// stalls, loading every corner a sample touches first; the checker predicts
// and compares, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int NUM_PHASES  = 7;
  localparam int PB = hbs_pkg::POS_BITS;
  localparam int AB = hbs_pkg::ADDR_BITS;
  localparam int CB = hbs_pkg::COORD_BITS;
  localparam int IB = hbs_pkg::CFG_IDX_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IB-1:0] cfg_index = hbs_pkg::REG_GRID_WIDTH;
  logic [PB-1:0] cfg_data = '0;
  int errors, pending;
  bit loaded [0:hbs_pkg::STORE_DEPTH-1];
  int cur_w, cur_h;
  bit no_gaps = 0;
  bit hold_results = 0;
  bit hold_done = 0;

  hbs_req_if req_ch();
  hbs_res_if res_ch();

  heightfield_bilinear_sampler_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req_ch), .res(res_ch)
  );

  hbs_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req_ch), .res(res_ch),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(hbs_pkg::req_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.data  = item;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic send_load(logic [AB-1:0] idx, logic [PB-1:0] h);
    hbs_pkg::req_t item;
    item.mode        = hbs_pkg::MODE_LOAD;
    item.load_index  = idx;
    item.load_height = h;
    item.coord_u     = CB'($urandom);
    item.coord_v     = CB'($urandom);
    loaded[idx] = 1'b1;
    send(item);
  endtask

  task automatic send_sample(logic [1:0] mode, logic [CB-1:0] u, logic [CB-1:0] v);
    int uc, vc, cx, cz;
    logic [AB-1:0] a;
    hbs_pkg::req_t item;
    uc = (u > CB'(65536)) ? 65536 : int'(u);
    vc = (v > CB'(65536)) ? 65536 : int'(v);
    cx = (uc * cur_w) >> 16;
    cz = (vc * cur_h) >> 16;
    if (cx >= cur_w - 1) cx = cur_w - 2;
    if (cz >= cur_h - 1) cz = cur_h - 2;
    for (int k = 0; k < 4; k++) begin
      a = AB'((cz + k / 2) * cur_w + cx + k % 2);
      if (!loaded[a]) send_load(a, PB'($urandom));
    end
    item.mode        = mode;
    item.load_index  = AB'($urandom);
    item.load_height = PB'($urandom);
    item.coord_u     = u;
    item.coord_v     = v;
    send(item);
  endtask

  task automatic write_reg(logic [IB-1:0] idx, logic [PB-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic int clamp_edge(int e);
    return (e < 2) ? 2 : ((e > 256) ? 256 : e);
  endfunction

  task automatic configure(int w, int h, logic [PB-1:0] xl, logic [PB-1:0] xh,
                           logic [PB-1:0] zl, logic [PB-1:0] zh);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    write_reg(hbs_pkg::REG_GRID_WIDTH, PB'(w));
    write_reg(hbs_pkg::REG_GRID_HEIGHT, PB'(h));
    write_reg(hbs_pkg::REG_X_MIN, xl);
    write_reg(hbs_pkg::REG_X_MAX, xh);
    write_reg(hbs_pkg::REG_Z_MIN, zl);
    write_reg(hbs_pkg::REG_Z_MAX, zh);
    cur_w = clamp_edge(w);
    cur_h = clamp_edge(h);
  endtask

  function automatic logic [CB-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CB'(65536);
    if (r == 2) return CB'($urandom_range(65537, 131071));
    return CB'($urandom_range(0, 65536));
  endfunction

  task automatic random_requests(int count);
    int r;
    hbs_pkg::req_t junk;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_sample(hbs_pkg::MODE_SMOOTH, rand_coord(), rand_coord());
      end else if (r < 90) begin
        send_sample(hbs_pkg::MODE_NEAREST, rand_coord(), rand_coord());
      end else if (r < 95) begin
        send_load(AB'($urandom), PB'($urandom));
      end else begin
        junk.mode        = hbs_pkg::MODE_NONE;
        junk.load_index  = AB'($urandom);
        junk.load_height = PB'($urandom);
        junk.coord_u     = CB'($urandom);
        junk.coord_v     = CB'($urandom);
        send(junk);
      end
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    res_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results && !hold_done) begin
        res_ch.ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_done = 1;
      end else if (no_gaps) begin
        res_ch.ready = 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        res_ch.ready = 1'b0;
        repeat ($urandom_range(10, 50)) @(negedge clk);
      end else begin
        res_ch.ready = ($urandom_range(0, 9) > 2);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    cur_w = 256;
    cur_h = 256;
    wait (!rst);
    configure(256, 256, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
    send_load(16'd0, 24'h7FFFFF);
    send_load(16'd1, 24'h800000);
    send_load(16'd256, 24'hFFFFFF);
    send_load(16'd257, 24'h7FFFFF);
    send_load(16'hFFFF, 24'h800000);
    send_sample(hbs_pkg::MODE_SMOOTH, 17'd0, 17'd0);
    send_sample(hbs_pkg::MODE_NEAREST, 17'd0, 17'd0);
    send_sample(hbs_pkg::MODE_SMOOTH, 17'd32768, 17'd32768);
    send_sample(hbs_pkg::MODE_SMOOTH, 17'd255, 17'd65535);
    send_sample(hbs_pkg::MODE_NEAREST, 17'd65536, 17'd65536);
    send_sample(hbs_pkg::MODE_SMOOTH, 17'd65536, 17'd65536);
    send_sample(hbs_pkg::MODE_SMOOTH, 17'h1FFFF, 17'd0);
    send_sample(hbs_pkg::MODE_NEAREST, 17'd0, 17'h1FFFF);
    send(hbs_pkg::req_t'({hbs_pkg::MODE_NONE, 16'hFFFF, 24'hFFFFFF, 17'h1FFFF,
                          17'h1FFFF}));
    send_sample(hbs_pkg::MODE_SMOOTH, 17'h1FFFF, 17'h1FFFF);
    for (int p = 1; p < NUM_PHASES; p++) begin
      case (p)
        1: configure(2, 2, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
        2: configure(0, 1, 24'h000000, 24'h000100, 24'hFFFF00, 24'h000000);
        3: configure(511, 300, PB'($urandom), PB'($urandom), PB'($urandom),
                     PB'($urandom));
        4: configure($urandom_range(3, 16), $urandom_range(3, 16),
                     PB'($urandom), PB'($urandom), PB'($urandom), PB'($urandom));
        default: configure($urandom_range(2, 40), $urandom_range(2, 40),
                           PB'($urandom), PB'($urandom), PB'($urandom),
                           PB'($urandom));
      endcase
      no_gaps = (p == 4);
      if (p == 2) hold_results = 1;
      random_requests(75);
      if (p == 3) wait (pending == 0);
    end
    no_gaps = 0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
